// ===== rtl/fjd_pkg.sv =====
// Package for the filament jam detector: word types, codes and reset constants.
`timescale 1ns / 1ps
`default_nettype none

package fjd_pkg;

   // Defaults for the top-level parameters
   localparam int PULSE_COUNT_BITS_DEF = 24;
   localparam int POSITION_BITS_DEF    = 32;

   // Fixed field widths
   localparam int REQ_TYPE_BITS    = 3;
   localparam int EXT_POS_BITS     = 32;
   localparam int PULSE_TOTAL_BITS = 24;
   localparam int PERIOD_BITS      = 8;
   localparam int PPM_BITS         = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;

   // Register reset values
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd2;
   localparam logic [PPM_BITS-1:0]    PPM_RESET    = 16'd256;
   localparam logic [PERIOD_BITS-1:0] TICK_MAX     = 8'd255;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK_PERIOD   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSES_PER_MM  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_HEATERS   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENCODER        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BULGE          = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWITCH         = 3'd5;

   typedef enum logic [REQ_TYPE_BITS-1:0] {
      REQ_PULSE   = 3'd0,
      REQ_TICK    = 3'd1,
      REQ_PIN     = 3'd2,
      REQ_COMMAND = 3'd3,
      REQ_ENABLE  = 3'd4,
      REQ_DISABLE = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      REPORT_NONE  = 2'd0,
      REPORT_JAM   = 2'd1,
      REPORT_BULGE = 2'd2
   } report_type;

   typedef struct packed {
      logic [REQ_TYPE_BITS-1:0]       req_type;
      logic signed [EXT_POS_BITS-1:0] extruder_pos;
      logic                           pos_valid;
      logic                           machine_suspended;
      logic                           bulge_level;
      logic                           switch_level;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                  report_kind;
      logic                        suspend_request;
      logic                        heaters_stay_on;
      logic [PULSE_TOTAL_BITS-1:0] pulse_total;
      logic                        triggered_flag;
      logic                        enabled_flag;
      logic                        alarm_pending;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/fjd_engine.sv =====
// Detector state, configuration registers and the per-word update logic.
`timescale 1ns / 1ps
`default_nettype none

module fjd_engine import fjd_pkg::*; #(
   parameter int PULSE_COUNT_BITS = PULSE_COUNT_BITS_DEF,
   parameter int POSITION_BITS    = POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      step_en,
   input  req_word_type              item,
   output rsp_word_type              result
);

   localparam int POS_W  = (POSITION_BITS < EXT_POS_BITS) ? POSITION_BITS : EXT_POS_BITS;
   localparam int PROD_W = POS_W + PPM_BITS;

   // configuration
   logic [PERIOD_BITS-1:0] period_ff;
   logic [PPM_BITS-1:0]    ppm_ff;
   logic                   keep_heat_ff;
   logic                   enc_ff;
   logic                   bulge_on_ff;
   logic                   switch_on_ff;

   // detector state
   logic [PULSE_COUNT_BITS-1:0] pulse_ff, pulse_in;
   logic [PERIOD_BITS-1:0]      tick_ff, tick_in;
   logic signed [POS_W-1:0]     last_pos_ff, last_pos_in;
   logic                        last_valid_ff, last_valid_in;
   logic                        retract_ff, retract_in;
   logic                        alarm_ff, alarm_in;
   logic                        bulge_flag_ff, bulge_flag_in;
   logic                        enabled_ff, enabled_in;
   logic                        tripped_ff, tripped_in;

   // check datapath
   logic signed [POS_W-1:0] now_pos;
   logic signed [POS_W:0]   delta;
   logic [PROD_W-1:0]       product;
   logic                    need_pulse;
   logic                    pin_hit;
   logic                    susp;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         ppm_ff       <= PPM_RESET;
         keep_heat_ff <= 1'b0;
         enc_ff       <= 1'b0;
         bulge_on_ff  <= 1'b0;
         switch_on_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CHECK_PERIOD:  period_ff    <= csr_wdata[PERIOD_BITS-1:0];
            CSR_PULSES_PER_MM: ppm_ff       <= csr_wdata[PPM_BITS-1:0];
            CSR_KEEP_HEATERS:  keep_heat_ff <= csr_wdata[0];
            CSR_ENCODER:       enc_ff       <= csr_wdata[0];
            CSR_BULGE:         bulge_on_ff  <= csr_wdata[0];
            CSR_SWITCH:        switch_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign now_pos    = item.extruder_pos[POS_W-1:0];
   assign delta      = {now_pos[POS_W-1], now_pos} - {last_pos_ff[POS_W-1], last_pos_ff};
   // travel * rate >= 2^16 means at least one pulse was due
   assign product    = delta[POS_W-1:0] * ppm_ff;
   assign need_pulse = |product[PROD_W-1:PPM_BITS];
   assign susp       = item.machine_suspended;
   assign pin_hit    = bulge_on_ff ? item.bulge_level : item.switch_level;

   always_comb begin
      pulse_in      = pulse_ff;
      tick_in       = tick_ff;
      last_pos_in   = last_pos_ff;
      last_valid_in = last_valid_ff;
      retract_in    = retract_ff;
      alarm_in      = alarm_ff;
      bulge_flag_in = bulge_flag_ff;
      enabled_in    = enabled_ff;
      tripped_in    = tripped_ff;
      result        = '0;

      if (step_en) begin
         unique case (req_code_type'(item.req_type))
            REQ_PULSE: begin
               if (!(&pulse_ff)) pulse_in = pulse_ff + 1'b1;
            end
            REQ_TICK: begin
               if (enc_ff) begin
                  if (tick_ff != TICK_MAX) tick_in = tick_ff + 1'b1;
                  if (tick_in >= period_ff) begin
                     tick_in = '0;
                     if (enabled_ff && !susp) begin
                        pulse_in = '0;
                        if (!item.pos_valid) begin
                           last_pos_in   = '0;
                           last_valid_in = 1'b0;
                        end else if (!last_valid_ff) begin
                           last_pos_in   = now_pos;
                           last_valid_in = 1'b1;
                        end else begin
                           last_pos_in = now_pos;
                           if (delta == '0) begin
                              // no move: nothing to check
                           end else if (delta[POS_W]) begin
                              retract_in = 1'b1;
                           end else if (retract_ff) begin
                              retract_in = 1'b0;
                           end else if (need_pulse && (pulse_ff == '0)) begin
                              alarm_in = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
            REQ_PIN: begin
               if ((bulge_on_ff || switch_on_ff) && enabled_ff && !susp && pin_hit) begin
                  alarm_in = 1'b1;
                  if (bulge_on_ff) bulge_flag_in = 1'b1;
               end
            end
            REQ_COMMAND: begin
               if (tripped_ff) begin
                  if (!susp) begin
                     tripped_in    = 1'b0;
                     pulse_in      = '0;
                     last_pos_in   = '0;
                     last_valid_in = 1'b0;
                  end
               end else if (enabled_ff && alarm_ff) begin
                  alarm_in = 1'b0;
                  if (bulge_flag_ff) begin
                     result.report_kind = REPORT_BULGE;
                     bulge_flag_in      = 1'b0;
                  end else begin
                     result.report_kind = REPORT_JAM;
                  end
                  if (!susp) begin
                     result.suspend_request = 1'b1;
                     result.heaters_stay_on = keep_heat_ff;
                     tripped_in             = 1'b1;
                  end
               end
            end
            REQ_ENABLE, REQ_DISABLE: begin
               pulse_in      = '0;
               enabled_in    = (req_code_type'(item.req_type) == REQ_ENABLE);
               last_pos_in   = item.pos_valid ? now_pos : '0;
               last_valid_in = item.pos_valid;
            end
            default: ;
         endcase
      end

      // a new check period restarts the tick count
      if (csr_we && (csr_index == CSR_CHECK_PERIOD)) tick_in = '0;

      result.pulse_total    = PULSE_TOTAL_BITS'(pulse_in);
      result.triggered_flag = tripped_in;
      result.enabled_flag   = enabled_in;
      result.alarm_pending  = alarm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff      <= '0;
         tick_ff       <= '0;
         last_pos_ff   <= '0;
         last_valid_ff <= 1'b0;
         retract_ff    <= 1'b0;
         alarm_ff      <= 1'b0;
         bulge_flag_ff <= 1'b0;
         enabled_ff    <= 1'b1;
         tripped_ff    <= 1'b0;
      end else begin
         pulse_ff      <= pulse_in;
         tick_ff       <= tick_in;
         last_pos_ff   <= last_pos_in;
         last_valid_ff <= last_valid_in;
         retract_ff    <= retract_in;
         alarm_ff      <= alarm_in;
         bulge_flag_ff <= bulge_flag_in;
         enabled_ff    <= enabled_in;
         tripped_ff    <= tripped_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/filament_jam_detector.sv =====
// Filament jam detector top level: input register, detector engine, result register.
//
// Usage:
//   Request words (req_valid/req_stall/req_word) carry one event each: encoder
//   pulse, one-second tick, pin poll, command poll, enable or disable, along
//   with the current extruder position (Q8 mm) and sensor pin levels.
//   Every accepted word yields exactly one result word on rsp_valid/rsp_stall/
//   rsp_word: the report and suspend request of a command poll plus the
//   detector status after the event.
//   An accepted word passes the input register, then the result register,
//   before rsp_valid rises; one word per cycle is sustained while the receiver
//   does not stall, with a single registered update of the detector state per
//   word (one 32x16 multiply and compare for the check).
//   When the receiver stalls, the result register holds its word and the input
//   register fills; req_stall rises once both are occupied.
//   Synchronous reset empties both registers, loads the register defaults
//   (period 2, 1 pulse/mm, all sensors absent) and leaves the detector enabled.
//   Write csr_* only while no words are in flight.
`timescale 1ns / 1ps
`default_nettype none

module filament_jam_detector import fjd_pkg::*; #(
   parameter int PULSE_COUNT_BITS = PULSE_COUNT_BITS_DEF,
   parameter int POSITION_BITS    = POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_word_type              req_word,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_word_type              rsp_word,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type step_result;
   logic         advance;
   logic         accept;

   // advance the held word whenever the result register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   fjd_engine #(
      .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
      .POSITION_BITS    (POSITION_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step_en   (advance),
      .item      (s1_word_ff),
      .result    (step_result)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold unless loading
   always_ff @(posedge clock) begin
      if (accept) s1_word_ff <= req_word;
      if (advance) rsp_word_ff <= step_result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a suspend request always leaves the detector tripped
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.suspend_request) |-> rsp_word.triggered_flag)
      else $error("suspend request without trip");

   // a report consumes the pending alarm
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.report_kind != REPORT_NONE)) |-> !rsp_word.alarm_pending)
      else $error("alarm still pending after report");

   // heaters flag only travels with a suspend request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.heaters_stay_on) |-> rsp_word.suspend_request)
      else $error("heaters flag without suspend request");

   // the input side only stalls while a word is held and cannot move on
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked word");

endmodule

`default_nettype wire

// ===== tb/filament_jam_detector_tb.sv =====
// Self-checking testbench for the filament jam detector: directed and random event traffic.
`timescale 1ns / 1ps

module filament_jam_detector_tb;
   import fjd_pkg::*;

   // Request codes that the block must ignore
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_TYPE_BITS-1:0] REQ_SPARE_HI = 3'd7;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 24;
   localparam int DRAIN_CYCLES  = 6;    // well past the block's latency
   localparam int PHASE_ITEMS   = 100;
   localparam int PHASE_COUNT   = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int PRINT_LIMIT   = 100;

   // Block ports; every input starts at a known value
   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   filament_jam_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted detector registers
   logic [PERIOD_BITS-1:0] cfg_period;
   logic [PPM_BITS-1:0]    cfg_ppm;
   logic                   cfg_keep_heat;
   logic                   cfg_encoder;
   logic                   cfg_bulge;
   logic                   cfg_switch;

   // Predicted detector state
   logic [PULSE_COUNT_BITS_DEF-1:0] pulses_seen;
   logic [PERIOD_BITS-1:0]          ticks_since_check;
   logic [EXT_POS_BITS-1:0]         last_pos;
   logic                            last_pos_ok;
   logic                            retract_pending;
   logic                            alarm_up;
   logic                            bulge_cause;
   logic                            det_enabled;
   logic                            det_tripped;

   // Status words still owed by the block, oldest first
   rsp_word_type status_q[$];

   int          errors       = 0;
   int          results_seen = 0;
   int          cycle_count  = 0;
   logic        calm         = 1'b0;   // suppress random idling on both sides
   int unsigned hold_wanted  = 0;      // request a long receiver hold-off
   int unsigned hold_left    = 0;
   int          walk_pos     = 0;      // extruder position for random traffic

   // Run the clock: 20 ns period
   initial begin
      forever #10 clock = ~clock;
   end

   // Abort the run if it never finishes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[filament_jam_detector] ERROR");
         $finish;
      end
   end

   // Print one line per mismatch, up to a cap, and count every one
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                  results_seen, what, got, want);
   endtask

   // Put the predicted registers and state in their reset values
   task automatic reset_prediction();
      cfg_period        = PERIOD_RESET;
      cfg_ppm           = PPM_RESET;
      cfg_keep_heat     = 1'b0;
      cfg_encoder       = 1'b0;
      cfg_bulge         = 1'b0;
      cfg_switch        = 1'b0;
      pulses_seen       = '0;
      ticks_since_check = '0;
      last_pos          = '0;
      last_pos_ok       = 1'b0;
      retract_pending   = 1'b0;
      alarm_up          = 1'b0;
      bulge_cause       = 1'b0;
      det_enabled       = 1'b1;
      det_tripped       = 1'b0;
   endtask

   // Latch the extruder position from an enable or disable word
   task automatic load_position(input req_word_type w);
      last_pos    = w.pos_valid ? w.extruder_pos : '0;
      last_pos_ok = w.pos_valid;
   endtask

   // Compare travel since the last check against the pulses counted
   task automatic encoder_check(input req_word_type w);
      logic [PULSE_COUNT_BITS_DEF-1:0] counted;
      logic signed [EXT_POS_BITS:0]    now_pos;
      logic signed [EXT_POS_BITS:0]    old_pos;
      logic signed [EXT_POS_BITS:0]    travel;
      logic [47:0]                     need_scaled;
      if (!det_enabled || w.machine_suspended) return;
      counted     = pulses_seen;
      pulses_seen = '0;
      if (!w.pos_valid) begin
         last_pos    = '0;
         last_pos_ok = 1'b0;
         return;
      end
      if (!last_pos_ok) begin
         last_pos    = w.extruder_pos;
         last_pos_ok = 1'b1;
         return;
      end
      now_pos  = {w.extruder_pos[EXT_POS_BITS-1], w.extruder_pos};
      old_pos  = {last_pos[EXT_POS_BITS-1], last_pos};
      travel   = now_pos - old_pos;
      last_pos = w.extruder_pos;
      if (travel == 0) return;
      if (travel < 0) begin
         retract_pending = 1'b1;
         return;
      end
      if (retract_pending) begin
         retract_pending = 1'b0;
         return;
      end
      // at least one pulse is needed when travel * rate reaches one in Q16
      need_scaled = {16'd0, travel[EXT_POS_BITS-1:0]} * {32'd0, cfg_ppm};
      if (need_scaled >= 48'd65536 && counted == 0) alarm_up = 1'b1;
   endtask

   // Advance the predicted detector by one accepted word and queue its status
   task automatic predict_status(input req_word_type w);
      rsp_word_type s;
      s = '0;
      case (w.req_type)
         REQ_PULSE: begin
            if (pulses_seen != '1) pulses_seen = pulses_seen + 1'b1;
         end
         REQ_TICK: begin
            if (cfg_encoder) begin
               if (ticks_since_check < TICK_MAX) ticks_since_check++;
               if (ticks_since_check >= cfg_period) begin
                  ticks_since_check = '0;
                  encoder_check(w);
               end
            end
         end
         REQ_PIN: begin
            if ((cfg_bulge || cfg_switch) && det_enabled && !w.machine_suspended) begin
               // the bulge sensor wins over the filament-out switch
               if (cfg_bulge ? w.bulge_level : w.switch_level) begin
                  alarm_up = 1'b1;
                  if (cfg_bulge) bulge_cause = 1'b1;
               end
            end
         end
         REQ_COMMAND: begin
            if (det_tripped) begin
               if (!w.machine_suspended) begin
                  det_tripped = 1'b0;
                  pulses_seen = '0;
                  last_pos    = '0;
                  last_pos_ok = 1'b0;
               end
            end else if (det_enabled && alarm_up) begin
               alarm_up = 1'b0;
               if (bulge_cause) begin
                  s.report_kind = REPORT_BULGE;
                  bulge_cause   = 1'b0;
               end else begin
                  s.report_kind = REPORT_JAM;
               end
               if (!w.machine_suspended) begin
                  s.suspend_request = 1'b1;
                  s.heaters_stay_on = cfg_keep_heat;
                  det_tripped       = 1'b1;
               end
            end
         end
         REQ_ENABLE: begin
            pulses_seen = '0;
            load_position(w);
            det_enabled = 1'b1;
         end
         REQ_DISABLE: begin
            pulses_seen = '0;
            det_enabled = 1'b0;
            load_position(w);
         end
         default: ;
      endcase
      s.pulse_total    = pulses_seen;
      s.triggered_flag = det_tripped;
      s.enabled_flag   = det_enabled;
      s.alarm_pending  = alarm_up;
      status_q.push_back(s);
   endtask

   // Offer one word; idle first at random, hold it until accepted.
   // Leave valid high on return so back-to-back words need no gap.
   task automatic send_word(input req_word_type w);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_status(w);
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed status word, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (status_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write one register; the block must be idle
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_CHECK_PERIOD: begin
            cfg_period        = value[PERIOD_BITS-1:0];
            ticks_since_check = '0;
         end
         CSR_PULSES_PER_MM: cfg_ppm       = value[PPM_BITS-1:0];
         CSR_KEEP_HEATERS:  cfg_keep_heat = value[0];
         CSR_ENCODER:       cfg_encoder   = value[0];
         CSR_BULGE:         cfg_bulge     = value[0];
         CSR_SWITCH:        cfg_switch    = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Load the whole register set; junk goes into the unused upper bits
   task automatic set_registers(input logic [PERIOD_BITS-1:0] period,
                                input logic [PPM_BITS-1:0] ppm,
                                input logic keep, input logic enc,
                                input logic bulge, input logic sw);
      write_reg(CSR_CHECK_PERIOD,  {8'($urandom), period});
      write_reg(CSR_PULSES_PER_MM, ppm);
      write_reg(CSR_KEEP_HEATERS,  {15'($urandom), keep});
      write_reg(CSR_ENCODER,       {15'($urandom), enc});
      write_reg(CSR_BULGE,         {15'($urandom), bulge});
      write_reg(CSR_SWITCH,        {15'($urandom), sw});
   endtask

   function automatic req_word_type make_word(input logic [REQ_TYPE_BITS-1:0] code,
                                              input logic [EXT_POS_BITS-1:0] pos,
                                              input logic ok, input logic susp,
                                              input logic bulge, input logic sw);
      req_word_type w;
      w.req_type          = code;
      w.extruder_pos      = pos;
      w.pos_valid         = ok;
      w.machine_suspended = susp;
      w.bulge_level       = bulge;
      w.switch_level      = sw;
      return w;
   endfunction

   // Mostly a forward-creeping extruder with small retracts; now and then
   // a wild position or a spare request code as noise
   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  pick;
      pick = $urandom_range(99);
      if (pick < 30)      w.req_type = REQ_PULSE;
      else if (pick < 56) w.req_type = REQ_TICK;
      else if (pick < 68) w.req_type = REQ_PIN;
      else if (pick < 84) w.req_type = REQ_COMMAND;
      else if (pick < 93) w.req_type = REQ_ENABLE;
      else if (pick < 97) w.req_type = REQ_DISABLE;
      else if (pick < 98) w.req_type = REQ_SPARE_LO;
      else                w.req_type = REQ_SPARE_HI;
      if ($urandom_range(19) == 0) walk_pos = int'($urandom);
      else walk_pos = walk_pos + int'($urandom_range(1500)) - 300;
      w.extruder_pos      = walk_pos;
      w.pos_valid         = ($urandom_range(9) != 0);
      w.machine_suspended = ($urandom_range(9) == 0);
      w.bulge_level       = ($urandom_range(3) == 0);
      w.switch_level      = ($urandom_range(3) == 0);
      return w;
   endfunction

   // Receiver: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_wanted != 0) begin
         hold_left   = hold_wanted;
         hold_wanted = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Check each accepted status word against the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (status_q.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_word, 0);
         end else begin
            want = status_q.pop_front();
            if (rsp_word.report_kind !== want.report_kind)
               report_mismatch("report_kind", rsp_word.report_kind, want.report_kind);
            if (rsp_word.suspend_request !== want.suspend_request)
               report_mismatch("suspend_request", rsp_word.suspend_request,
                               want.suspend_request);
            if (rsp_word.heaters_stay_on !== want.heaters_stay_on)
               report_mismatch("heaters_stay_on", rsp_word.heaters_stay_on,
                               want.heaters_stay_on);
            if (rsp_word.pulse_total !== want.pulse_total)
               report_mismatch("pulse_total", rsp_word.pulse_total, want.pulse_total);
            if (rsp_word.triggered_flag !== want.triggered_flag)
               report_mismatch("triggered_flag", rsp_word.triggered_flag,
                               want.triggered_flag);
            if (rsp_word.enabled_flag !== want.enabled_flag)
               report_mismatch("enabled_flag", rsp_word.enabled_flag, want.enabled_flag);
            if (rsp_word.alarm_pending !== want.alarm_pending)
               report_mismatch("alarm_pending", rsp_word.alarm_pending, want.alarm_pending);
         end
      end
   end

   // Defaults straight out of reset: nothing pending, spare codes ignored
   task automatic test_reset_defaults();
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_SPARE_LO, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
      send_word(make_word(REQ_SPARE_HI, 32'h8000_0000, 1'b1, 1'b0, 1'b1, 1'b1));
      drain();
   endtask

   // Periodic encoder check: jam, trip and clear, retract, zero move,
   // lost position, extreme positions and the rate extreme
   task automatic test_encoder_check();
      set_registers(8'd1, 16'd256, 1'b0, 1'b1, 1'b0, 1'b0);
      send_word(make_word(REQ_ENABLE, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_TICK, 32'd256, 1'b1, 1'b0, 1'b0, 1'b0));     // 1 mm, no pulse
      send_word(make_word(REQ_COMMAND, 32'd256, 1'b1, 1'b0, 1'b0, 1'b0));  // trips
      send_word(make_word(REQ_COMMAND, 32'd256, 1'b1, 1'b1, 1'b0, 1'b0));  // still suspended
      send_word(make_word(REQ_COMMAND, 32'd256, 1'b1, 1'b0, 1'b0, 1'b0));  // clears trip
      send_word(make_word(REQ_TICK, 32'd512, 1'b1, 1'b0, 1'b0, 1'b0));     // relearn position
      send_word(make_word(REQ_TICK, 32'd256, 1'b1, 1'b0, 1'b0, 1'b0));     // retract
      send_word(make_word(REQ_TICK, 32'd1024, 1'b1, 1'b0, 1'b0, 1'b0));    // first extrude
      send_word(make_word(REQ_PULSE, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_TICK, 32'd2048, 1'b1, 1'b0, 1'b0, 1'b0));    // pulse came
      send_word(make_word(REQ_TICK, 32'd2048, 1'b1, 1'b0, 1'b0, 1'b0));    // zero move
      send_word(make_word(REQ_TICK, 32'd4096, 1'b0, 1'b0, 1'b0, 1'b0));    // position lost
      send_word(make_word(REQ_TICK, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_TICK, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0)); // full retract
      drain();
      // fastest rate with a zero period: one Q8 step is just short of a pulse
      set_registers(8'd0, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
      send_word(make_word(REQ_TICK, 32'h8000_0001, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_TICK, 32'h8000_0002, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_TICK, 32'h8000_0004, 1'b1, 1'b0, 1'b0, 1'b0));
      drain();
   endtask

   // Pin polls: bulge over switch, suspended polls, kept heaters, disabled
   task automatic test_pin_sensors();
      set_registers(8'd2, 16'd256, 1'b1, 1'b0, 1'b1, 1'b1);
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));    // flush old alarm
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_PIN, 32'd0, 1'b0, 1'b1, 1'b1, 1'b1));        // suspended
      send_word(make_word(REQ_PIN, 32'd0, 1'b0, 1'b0, 1'b0, 1'b1));        // switch ignored
      send_word(make_word(REQ_PIN, 32'd0, 1'b0, 1'b0, 1'b1, 1'b0));        // bulge
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      drain();
      write_reg(CSR_BULGE, 16'd0);
      send_word(make_word(REQ_PIN, 32'd0, 1'b0, 1'b0, 1'b1, 1'b1));        // switch alone
      send_word(make_word(REQ_DISABLE, 32'd77, 1'b0, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0));    // disabled
      send_word(make_word(REQ_ENABLE, 32'd77, 1'b1, 1'b0, 1'b0, 1'b0));
      send_word(make_word(REQ_COMMAND, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0));    // report only
      drain();
   endtask

   // Random traffic in phases, each with its own register set
   task automatic test_random_traffic();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: set_registers(8'd1, 16'd256, 1'b0, 1'b1, 1'b0, 1'b1);
            1: set_registers(8'd2, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
            2: set_registers(8'd3, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0);
            3: set_registers(8'd255, 16'd1, 1'b1, 1'b1, 1'b1, 1'b0);
            default: set_registers(8'($urandom_range(1, 6)), 16'($urandom),
                                   1'($urandom), 1'($urandom), 1'($urandom),
                                   1'($urandom));
         endcase
         // run the first phase without any idling
         calm = (phase == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off the receiver while words keep coming, to fill the block
            if (phase == 1 && n == 20) hold_wanted = HOLD_CYCLES;
            // pause the sender until every result is in
            if (phase == 2 && n == 50) drain();
            send_word(random_word());
         end
         drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset_prediction();
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_encoder_check();
      test_pin_sensors();
      test_random_traffic();
      drain();
      if (errors == 0)
         $display("[filament_jam_detector] OK");
      else
         $display("[filament_jam_detector] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/fjd_pkg.sv
rtl/fjd_engine.sv
rtl/filament_jam_detector.sv
tb/filament_jam_detector_tb.sv
